### sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared widths, constants and the arctangent table for the Cartesian to
// polar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

   // Coordinate width of both input fields.
   localparam int COORD_WIDTH  = 16;
   // Fixed widths of the result fields.
   localparam int MAG_W        = 16;
   localparam int ANG_OUT_W    = 16;

   // CORDIC set-up: step count, guard bits, accumulator width (2^24 = turn).
   localparam int CORDIC_STEPS = 20;
   localparam int GUARD_BITS   = 20;
   localparam int ANGLE_W      = 24;
   localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);

   // Datapath width: coordinate, guard bits, CORDIC gain and sign headroom.
   localparam int DATA_W       = COORD_WIDTH + GUARD_BITS + 3;

   // Integer square root: radicand, root and partial remainder widths.
   localparam int SQ_W         = 2 * COORD_WIDTH;
   localparam int ROOT_W       = COORD_WIDTH;
   localparam int REM_W        = ROOT_W + 2;

   // Number of iterative stages: the longer of the two iterations.
   localparam int PIPE_STEPS   = (CORDIC_STEPS > ROOT_W) ? CORDIC_STEPS : ROOT_W;

   // Rounding offset when dropping from ANGLE_W to ANG_OUT_W bits.
   localparam int ANG_DROP     = ANGLE_W - ANG_OUT_W;
   localparam logic [ANGLE_W-1:0] ANG_ROUND = ANGLE_W'(1) << (ANG_DROP - 1);

   // Half a turn in accumulator units (pre-rotation of the left half-plane).
   localparam logic [ANGLE_W-1:0] Z_HALF_TURN = ANGLE_W'(1) << (ANGLE_W - 1);

   // Exact axis angles in output units.
   localparam logic [ANG_OUT_W-1:0] ANG_POS_X = ANG_OUT_W'(0);
   localparam logic [ANG_OUT_W-1:0] ANG_POS_Y = ANG_OUT_W'(16384);
   localparam logic [ANG_OUT_W-1:0] ANG_NEG_X = ANG_OUT_W'(32768);
   localparam logic [ANG_OUT_W-1:0] ANG_NEG_Y = ANG_OUT_W'(49152);

   // Bound on the magnitude the 16-bit coordinate range can produce.
   localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(46341);

   // atan(2^-i) in accumulator units.
   function automatic logic [ANGLE_W-1:0] atan_step(input logic [STEP_IDX_W-1:0] idx);
      logic [ANGLE_W-1:0] val;
      case (idx)
         5'd0:    val = 24'd2097152;
         5'd1:    val = 24'd1238021;
         5'd2:    val = 24'd654136;
         5'd3:    val = 24'd332050;
         5'd4:    val = 24'd166669;
         5'd5:    val = 24'd83416;
         5'd6:    val = 24'd41718;
         5'd7:    val = 24'd20860;
         5'd8:    val = 24'd10430;
         5'd9:    val = 24'd5215;
         5'd10:   val = 24'd2608;
         5'd11:   val = 24'd1304;
         5'd12:   val = 24'd652;
         5'd13:   val = 24'd326;
         5'd14:   val = 24'd163;
         5'd15:   val = 24'd81;
         5'd16:   val = 24'd41;
         5'd17:   val = 24'd20;
         5'd18:   val = 24'd10;
         5'd19:   val = 24'd5;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Front stage: squares and the pre-rotated CORDIC vector.
   typedef struct packed {
      logic                      valid;
      logic                      x_zero;
      logic                      y_zero;
      logic                      x_neg;
      logic                      y_pos;
      logic signed [DATA_W-1:0]  cx;
      logic signed [DATA_W-1:0]  cy;
      logic [ANGLE_W-1:0]        z;
      logic [SQ_W-1:0]           sq_x;
      logic [SQ_W-1:0]           sq_y;
   } prep_type;

   // One iterative stage: CORDIC vector plus square-root state.
   typedef struct packed {
      logic                      valid;
      logic                      x_zero;
      logic                      y_zero;
      logic                      x_neg;
      logic                      y_pos;
      logic signed [DATA_W-1:0]  cx;
      logic signed [DATA_W-1:0]  cy;
      logic [ANGLE_W-1:0]        z;
      logic [SQ_W-1:0]           rad;
      logic [REM_W-1:0]          rem;
      logic [ROOT_W-1:0]         root;
   } stage_type;

endpackage

`default_nettype wire

### sv/cartesian_to_polar_unit.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_unit
// Pipelined Cartesian to polar converter: exact integer magnitude and a
// 16-bit binary angle from a vectoring CORDIC.
// ----------------------------------------------------------------------------
//
//   channel | direction | beat contents                   | flow control
//   --------+-----------+---------------------------------+--------------
//   req     | in        | real_part, imag_part (signed)   | valid / stall
//   rsp     | out       | magnitude, angle_turns          | valid / stall
//
// One beat enters per clock unless stalled. Stages: a front stage (squares,
// pre-rotation), a sum stage, 20 CORDIC stages (the square root runs its
// 16 bit-steps alongside the first 16 of them) and an output register.
// The CORDIC step count sets the depth.
// Reset clears the valid bits of every stage; payload is left as is.
// A stalled result freezes the whole pipe and raises req_stall the same
// cycle, so nothing is dropped or repeated. Bubbles are not squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_polar_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [c2p_pkg::COORD_WIDTH-1:0]  req_real_part,
   input  wire logic [c2p_pkg::COORD_WIDTH-1:0]  req_imag_part,
   // response channel
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [c2p_pkg::MAG_W-1:0]        rsp_magnitude,
   output      logic [c2p_pkg::ANG_OUT_W-1:0]    rsp_angle_turns
);
   import c2p_pkg::*;

   // Pipe advance: everything moves unless a finished beat is held.
   logic rsp_valid_ff;
   logic hold;
   logic advance;

   assign hold      = rsp_valid_ff & rsp_stall;
   assign advance   = ~hold;
   assign req_stall = hold;

   // ------------------------------------------------------------------
   // Front stage: absolute values, squares, left half-plane pre-rotation.
   // ------------------------------------------------------------------
   prep_type prep_in;
   prep_type prep_ff;

   logic signed [COORD_WIDTH-1:0] x_s;
   logic signed [COORD_WIDTH-1:0] y_s;
   logic [COORD_WIDTH-1:0]        ax;
   logic [COORD_WIDTH-1:0]        ay;
   logic signed [DATA_W-1:0]      x_sc;
   logic signed [DATA_W-1:0]      y_sc;

   always_comb begin
      x_s  = signed'(req_real_part);
      y_s  = signed'(req_imag_part);
      // two's complement magnitude; the most negative value maps to 2^(W-1)
      ax   = x_s[COORD_WIDTH-1] ? (~req_real_part + 1'b1) : req_real_part;
      ay   = y_s[COORD_WIDTH-1] ? (~req_imag_part + 1'b1) : req_imag_part;
      x_sc = DATA_W'(x_s) <<< GUARD_BITS;
      y_sc = DATA_W'(y_s) <<< GUARD_BITS;

      prep_in.valid  = req_valid;
      prep_in.x_zero = (req_real_part == '0);
      prep_in.y_zero = (req_imag_part == '0);
      prep_in.x_neg  = x_s[COORD_WIDTH-1];
      prep_in.y_pos  = ~y_s[COORD_WIDTH-1] & (req_imag_part != '0);
      prep_in.sq_x   = SQ_W'(ax) * SQ_W'(ax);
      prep_in.sq_y   = SQ_W'(ay) * SQ_W'(ay);
      if (x_s[COORD_WIDTH-1]) begin
         prep_in.cx = -x_sc;
         prep_in.cy = -y_sc;
         prep_in.z  = Z_HALF_TURN;
      end else begin
         prep_in.cx = x_sc;
         prep_in.cy = y_sc;
         prep_in.z  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         prep_ff <= prep_in;
      end
   end

   // ------------------------------------------------------------------
   // Sum stage: radicand for the square root; CORDIC vector passes on.
   // ------------------------------------------------------------------
   stage_type pipe_in [0:PIPE_STEPS];
   stage_type pipe_ff [0:PIPE_STEPS];

   always_comb begin
      pipe_in[0].valid  = prep_ff.valid;
      pipe_in[0].x_zero = prep_ff.x_zero;
      pipe_in[0].y_zero = prep_ff.y_zero;
      pipe_in[0].x_neg  = prep_ff.x_neg;
      pipe_in[0].y_pos  = prep_ff.y_pos;
      pipe_in[0].cx     = prep_ff.cx;
      pipe_in[0].cy     = prep_ff.cy;
      pipe_in[0].z      = prep_ff.z;
      pipe_in[0].rad    = prep_ff.sq_x + prep_ff.sq_y;
      pipe_in[0].rem    = '0;
      pipe_in[0].root   = '0;
   end

   // ------------------------------------------------------------------
   // Iterative stages. Stage k does CORDIC step k and, while bits remain,
   // one restoring square-root step on the next two radicand bits.
   // ------------------------------------------------------------------
   for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
      // radicand pair for this step; unused once the root is complete
      localparam int PAIR_LO = (k < ROOT_W) ? 2 * (ROOT_W - 1 - k) : 0;

      logic signed [DATA_W-1:0] xs;
      logic signed [DATA_W-1:0] ys;
      logic                     rotate_down;
      logic [REM_W-1:0]         rem_sh;
      logic [REM_W-1:0]         trial;

      always_comb begin
         pipe_in[k+1] = pipe_ff[k];

         // vectoring CORDIC: drive y towards zero, floor shifts
         xs          = pipe_ff[k].cx >>> k;
         ys          = pipe_ff[k].cy >>> k;
         rotate_down = ~pipe_ff[k].cy[DATA_W-1] & (pipe_ff[k].cy != '0);
         if (k < CORDIC_STEPS) begin
            if (rotate_down) begin
               pipe_in[k+1].cx = pipe_ff[k].cx + ys;
               pipe_in[k+1].cy = pipe_ff[k].cy - xs;
               pipe_in[k+1].z  = pipe_ff[k].z + atan_step(STEP_IDX_W'(k));
            end else begin
               pipe_in[k+1].cx = pipe_ff[k].cx - ys;
               pipe_in[k+1].cy = pipe_ff[k].cy + xs;
               pipe_in[k+1].z  = pipe_ff[k].z - atan_step(STEP_IDX_W'(k));
            end
         end

         // restoring square root, most significant pair first
         rem_sh = '0;
         trial  = '0;
         if (k < ROOT_W) begin
            rem_sh = {pipe_ff[k].rem[REM_W-3:0],
                      pipe_ff[k].rad[PAIR_LO +: 2]};
            trial  = {pipe_ff[k].root, 2'b01};
            if (rem_sh >= trial) begin
               pipe_in[k+1].rem  = rem_sh - trial;
               pipe_in[k+1].root = {pipe_ff[k].root[ROOT_W-2:0], 1'b1};
            end else begin
               pipe_in[k+1].rem  = rem_sh;
               pipe_in[k+1].root = {pipe_ff[k].root[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   for (genvar k = 0; k <= PIPE_STEPS; k++) begin : g_pipe_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[k].valid <= 1'b0;
         end else if (advance) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: round the angle, pick axis cases, saturate magnitude.
   // ------------------------------------------------------------------
   logic [MAG_W-1:0]        rsp_magnitude_ff;
   logic [ANG_OUT_W-1:0]    rsp_angle_ff;
   logic [MAG_W-1:0]        mag_in;
   logic [ANG_OUT_W-1:0]    ang_in;
   logic [ANGLE_W-1:0]      z_round;
   stage_type               last;

   always_comb begin
      last    = pipe_ff[PIPE_STEPS];
      // round half up; a carry out of the top wraps to zero
      z_round = last.z + ANG_ROUND;

      if (last.y_zero) begin
         ang_in = last.x_neg ? ANG_NEG_X : ANG_POS_X;
      end else if (last.x_zero) begin
         ang_in = last.y_pos ? ANG_POS_Y : ANG_NEG_Y;
      end else begin
         ang_in = z_round[ANGLE_W-1 -: ANG_OUT_W];
      end

      if (64'(last.root) > 64'({MAG_W{1'b1}})) begin
         mag_in = '1;
      end else begin
         mag_in = MAG_W'(last.root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_magnitude_ff <= mag_in;
         rsp_angle_ff     <= ang_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_magnitude   = rsp_magnitude_ff;
   assign rsp_angle_turns = rsp_angle_ff;

endmodule

`default_nettype wire

### sv/c2p_checker.sv
// ----------------------------------------------------------------------------
// c2p_checker
// Port-level checks for the Cartesian to polar converter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic [c2p_pkg::COORD_WIDTH-1:0]  req_real_part,
   input wire logic [c2p_pkg::COORD_WIDTH-1:0]  req_imag_part,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [c2p_pkg::MAG_W-1:0]        rsp_magnitude,
   input wire logic [c2p_pkg::ANG_OUT_W-1:0]    rsp_angle_turns
);
   import c2p_pkg::*;

   // no result beat straight out of reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // the input side is held back only by a held result beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // a held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_magnitude) && $stable(rsp_angle_turns)))
      else $error("held result beat changed");

   // magnitude never exceeds the reach of the coordinate range
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_magnitude <= MAG_LIMIT))
      else $error("magnitude out of range");

endmodule

bind cartesian_to_polar_unit c2p_checker u_c2p_checker (.*);

`default_nettype wire
